>>> rtl/core/multithread_issue_core_unit_assert.svh
// Assertion macros shared by the core files
`ifndef MULTITHREAD_ISSUE_CORE_UNIT_ASSERT_SVH
`define MULTITHREAD_ISSUE_CORE_UNIT_ASSERT_SVH
// implication checked at every edge outside reset
`define MIC_ASSERT_IMPL(lbl, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define MIC_ASSERT_NEXT(lbl, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> rtl/core/mic_pkg.sv
package mic_pkg;
   localparam int MaxThreads = 8;
   localparam int NumRegs    = 8;
   localparam int LineBits   = 16;
   localparam int TidW       = $clog2(MaxThreads);
   localparam int RegW       = $clog2(NumRegs);
   localparam int CntW       = 48;
   localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

   localparam logic [1:0] MODE_ADV  = 2'd0;
   localparam logic [1:0] MODE_EXE  = 2'd1;
   localparam logic [1:0] MODE_LDR  = 2'd2;
   localparam logic [1:0] MODE_SKIP = 2'd3;

   localparam logic [2:0] OP_NOP   = 3'd0;
   localparam logic [2:0] OP_ADD   = 3'd1;
   localparam logic [2:0] OP_SUB   = 3'd2;
   localparam logic [2:0] OP_ADDI  = 3'd3;
   localparam logic [2:0] OP_SUBI  = 3'd4;
   localparam logic [2:0] OP_LOAD  = 3'd5;
   localparam logic [2:0] OP_STORE = 3'd6;
   localparam logic [2:0] OP_HALT  = 3'd7;

   localparam logic [2:0] CSR_MT_MODE   = 3'd0;
   localparam logic [2:0] CSR_ACTIVE    = 3'd1;
   localparam logic [2:0] CSR_LOAD_LAT  = 3'd2;
   localparam logic [2:0] CSR_STORE_LAT = 3'd3;
   localparam logic [2:0] CSR_SW_PEN    = 3'd4;

   // controller -> datapath
   typedef struct packed {
      logic adv;      // advance step 1 (tick, pick)
      logic adv2;     // advance step 2 (penalty, fetch, result)
      logic exe_rd;   // execute step 1: register read
      logic exe_rd2;  // store only: base register read
      logic exe_wb;   // execute last step: write back, result
      logic ldr;      // load return write, result
      logic skip;     // unused mode: result only
      logic clear;    // clearing pass write
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic done;
      logic extra;    // latched op needs the base register read
   } dp_sts_type;
endpackage

>>> rtl/core/mic_ctrl.sv
module mic_ctrl
   import mic_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] mode,
   output logic       busy,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);
   localparam logic [2:0] ST_CLR  = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_ADV2 = 3'd2;
   localparam logic [2:0] ST_EXE2 = 3'd3;
   localparam logic [2:0] ST_EXE3 = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       take;

   assign busy = (state_ff != ST_IDLE);
   assign take = start && !busy;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLR: begin
            cmd.clear = 1'b1;
            if (sts.done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (take) begin
               case (mode)
                  MODE_ADV: begin cmd.adv = 1'b1; state_in = ST_ADV2; end
                  MODE_EXE: begin cmd.exe_rd = 1'b1; state_in = ST_EXE2; end
                  MODE_LDR: cmd.ldr = 1'b1;
                  default:  cmd.skip = 1'b1;
               endcase
            end
         end
         ST_ADV2: begin cmd.adv2 = 1'b1; state_in = ST_IDLE; end
         ST_EXE2: begin
            if (sts.extra) begin
               cmd.exe_rd2 = 1'b1;
               state_in = ST_EXE3;
            end else begin
               cmd.exe_wb = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EXE3: begin cmd.exe_wb = 1'b1; state_in = ST_IDLE; end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLR;
      else       state_ff <= state_in;
   end

   `include "multithread_issue_core_unit_assert.svh"
   `MIC_ASSERT_NEXT(a_adv_two, reset, cmd.adv, state_ff == ST_ADV2, "advance lost step")
   `MIC_ASSERT_NEXT(a_exe_two, reset, cmd.exe_rd, state_ff == ST_EXE2, "execute lost step")
   `MIC_ASSERT_NEXT(a_exe_three, reset, cmd.exe_rd2, state_ff == ST_EXE3, "store lost step")
   `MIC_ASSERT_IMPL(a_one_cmd, reset, 1'b1, $onehot0(cmd), "several commands at once")
endmodule

>>> rtl/core/mic_dp.sv
module mic_dp
   import mic_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_sts_type        sts,
   input  logic              cfg_mt_mode,
   input  logic [3:0]        cfg_active,
   input  logic [7:0]        cfg_load_lat,
   input  logic [7:0]        cfg_store_lat,
   input  logic [7:0]        cfg_sw_pen,
   input  logic [2:0]        opcode,
   input  logic [2:0]        dest_reg,
   input  logic [2:0]        src1_reg,
   input  logic signed [31:0] src2_or_imm,
   input  logic              src2_is_imm,
   input  logic signed [31:0] load_data,
   output logic              rsp_valid,
   output logic              rsp_idle,
   output logic              rsp_all_halted,
   output logic [2:0]        rsp_thread_id,
   output logic [15:0]       rsp_instr_line,
   output logic              rsp_mem_read,
   output logic              rsp_mem_write,
   output logic signed [31:0] rsp_mem_address,
   output logic signed [31:0] rsp_store_data,
   output logic [47:0]       rsp_cycle_count,
   output logic [47:0]       rsp_instr_count
);
   localparam int RfDepth = MaxThreads * NumRegs;
   localparam int RfAw    = $clog2(RfDepth);

   // register file: two read ports, one write port
   logic [31:0] rf_mem [RfDepth];
   logic [31:0] rd_a_ff, rd_b_ff, rd_c_ff;
   logic [RfAw:0] clr_ff;
   logic [RfAw-1:0] wr_addr, ra_a, ra_b, ra_p2;
   logic [31:0]     wr_data;
   logic            wr_en;

   logic [8:0]          stall_ff [MaxThreads];
   logic [MaxThreads-1:0] halted_ff;
   logic [LineBits-1:0] line_ff [MaxThreads];
   logic [TidW-1:0]     cur_ff;
   logic                first_ff;
   logic [RegW-1:0]     pend_ff;
   logic [CntW-1:0]     cyc_ff, ins_ff;

   // latched input beat
   logic [2:0]  op_ff;
   logic [RegW-1:0] rd_ff;
   logic [31:0] s2_ff;
   logic        imm_ff;
   logic        sel_ff, live_ff;
   logic [TidW-1:0] pick_ff;

   logic [4:0] n_act;
   logic [MaxThreads-1:0] active_m, ready_m;
   logic every_halted;

   always_comb begin
      if (cfg_active == 4'd0) n_act = 5'd1;
      else if ({1'b0, cfg_active} > 5'(MaxThreads)) n_act = 5'(MaxThreads);
      else n_act = {1'b0, cfg_active};
      for (int i = 0; i < MaxThreads; i++) active_m[i] = (5'(i) < n_act);
      every_halted = ((active_m & ~halted_ff) == '0);
   end

   // ready when the stall count is at most one, so it is clear after the tick
   always_comb begin
      for (int i = 0; i < MaxThreads; i++)
         ready_m[i] = active_m[i] && !halted_ff[i] && (stall_ff[i] <= 9'd1);
   end

   // rotating search from the current thread; any ready thread selects,
   // the fine-grained skip only moves the pick (falls back to current)
   logic [TidW-1:0] pick;
   logic            found;
   always_comb begin
      logic [TidW-1:0] idx;
      pick  = cur_ff;
      found = |ready_m;
      for (int k = MaxThreads - 1; k >= 0; k--) begin
         idx = cur_ff + TidW'(k);
         if (ready_m[idx] && !(k == 0 && cfg_mt_mode && !first_ff)) pick = idx;
      end
   end

   function automatic logic [CntW-1:0] sat_add(logic [CntW-1:0] a, logic [CntW-1:0] b);
      logic [CntW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CntW] ? CntMax : s[CntW-1:0];
   endfunction

   assign ra_a = {cur_ff, src1_reg[RegW-1:0]};
   assign ra_b = {cur_ff, src2_or_imm[RegW-1:0]};
   // port two: second operand on the accepting edge, store base in the cycle after
   assign ra_p2 = cmd.exe_rd2 ? {cur_ff, rd_ff} : ra_b;

   always_ff @(posedge clock) begin
      if (wr_en) rf_mem[wr_addr] <= wr_data;
      if (cmd.exe_rd) rd_a_ff <= rf_mem[ra_a];
      if (cmd.exe_rd) rd_b_ff <= rf_mem[ra_p2];
      if (cmd.exe_rd2) rd_c_ff <= rf_mem[ra_p2];
   end

   logic [31:0] second, alu;
   assign second = imm_ff ? s2_ff : rd_b_ff;
   always_comb begin
      case (op_ff)
         OP_ADD:  alu = rd_a_ff + rd_b_ff;
         OP_SUB:  alu = rd_a_ff - rd_b_ff;
         OP_ADDI: alu = rd_a_ff + s2_ff;
         OP_SUBI: alu = rd_a_ff - s2_ff;
         default: alu = rd_a_ff + second;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {cur_ff, rd_ff};
      wr_data = alu;
      if (cmd.clear) begin
         wr_en = 1'b1; wr_addr = clr_ff[RfAw-1:0]; wr_data = '0;
      end else if (cmd.ldr) begin
         wr_en = 1'b1; wr_addr = {cur_ff, pend_ff}; wr_data = load_data;
      end else if (cmd.exe_wb && live_ff) begin
         wr_en = (op_ff == OP_ADD) || (op_ff == OP_SUB) ||
                 (op_ff == OP_ADDI) || (op_ff == OP_SUBI);
      end
   end

   assign sts = '{done: clr_ff[RfAw], extra: (op_ff == OP_STORE)};

   logic [8:0] pen9;
   assign pen9 = {1'b0, cfg_sw_pen};

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff    <= '0;
         halted_ff <= '0;
         cur_ff    <= '0;
         first_ff  <= 1'b1;
         pend_ff   <= '0;
         cyc_ff    <= '0;
         ins_ff    <= '0;
         rsp_valid <= 1'b0;
         for (int i = 0; i < MaxThreads; i++) begin
            stall_ff[i] <= '0;
            line_ff[i]  <= '0;
         end
      end else begin
         rsp_valid <= 1'b0;
         if (cmd.clear) clr_ff <= clr_ff + 1'b1;
         if (cmd.adv || cmd.exe_rd) begin
            op_ff  <= opcode;
            rd_ff  <= dest_reg[RegW-1:0];
            s2_ff  <= src2_or_imm;
            imm_ff <= src2_is_imm;
            live_ff <= active_m[cur_ff] && !halted_ff[cur_ff];
         end
         if (cmd.adv) begin
            sel_ff <= !every_halted && found;
            pick_ff <= pick;
            if (!every_halted) begin
               for (int i = 0; i < MaxThreads; i++)
                  stall_ff[i] <= (stall_ff[i] > 9'd1) ? stall_ff[i] - 9'd1 : 9'd0;
               if (!found) cyc_ff <= sat_add(cyc_ff, 48'd1);
            end
         end
         if (cmd.adv2) begin
            rsp_valid <= 1'b1;
            rsp_idle  <= !sel_ff;
            rsp_instr_line <= '0;
            rsp_mem_read <= 1'b0; rsp_mem_write <= 1'b0;
            rsp_mem_address <= '0; rsp_store_data <= '0;
            rsp_all_halted <= every_halted;
            rsp_cycle_count <= cyc_ff;
            rsp_thread_id <= 3'(cur_ff);
            if (sel_ff) begin
               if (!cfg_mt_mode && pick_ff != cur_ff) begin
                  rsp_cycle_count <= sat_add(cyc_ff, 48'(cfg_sw_pen));
                  cyc_ff <= sat_add(cyc_ff, 48'(cfg_sw_pen));
                  for (int i = 0; i < MaxThreads; i++)
                     stall_ff[i] <= (stall_ff[i] > pen9) ? stall_ff[i] - pen9 : 9'd0;
               end
               cur_ff <= pick_ff;
               rsp_thread_id <= 3'(pick_ff);
               rsp_instr_line <= 16'(line_ff[pick_ff]);
               line_ff[pick_ff] <= line_ff[pick_ff] + 1'b1;
            end
            rsp_instr_count <= ins_ff;
         end
         if (cmd.exe_wb) begin
            logic [CntW-1:0] c1, i1;
            c1 = live_ff ? sat_add(cyc_ff, 48'd1) : cyc_ff;
            i1 = live_ff ? sat_add(ins_ff, 48'd1) : ins_ff;
            rsp_valid <= 1'b1;
            rsp_idle <= 1'b0;
            rsp_thread_id <= 3'(cur_ff);
            rsp_instr_line <= '0;
            rsp_mem_read <= 1'b0; rsp_mem_write <= 1'b0;
            rsp_mem_address <= '0; rsp_store_data <= '0;
            rsp_cycle_count <= c1; rsp_instr_count <= i1;
            rsp_all_halted <= every_halted;
            if (live_ff) begin
               cyc_ff <= c1; ins_ff <= i1; first_ff <= 1'b0;
               case (op_ff)
                  OP_NOP: stall_ff[cur_ff] <= stall_ff[cur_ff];
                  OP_LOAD: begin
                     rsp_mem_read <= 1'b1;
                     rsp_mem_address <= rd_a_ff + second;
                     pend_ff <= rd_ff;
                     stall_ff[cur_ff] <= 9'd1 + {1'b0, cfg_load_lat};
                  end
                  OP_STORE: begin
                     rsp_mem_write <= 1'b1;
                     rsp_mem_address <= rd_c_ff + second;
                     rsp_store_data <= rd_a_ff;
                     stall_ff[cur_ff] <= 9'd1 + {1'b0, cfg_store_lat};
                  end
                  OP_HALT: begin
                     halted_ff[cur_ff] <= 1'b1;
                     stall_ff[cur_ff] <= 9'd1;
                     rsp_all_halted <= ((active_m & ~(halted_ff |
                        (MaxThreads'(1) << cur_ff))) == '0);
                  end
                  default: stall_ff[cur_ff] <= 9'd1;
               endcase
            end
         end
         if (cmd.ldr || cmd.skip) begin
            rsp_valid <= 1'b1;
            rsp_idle <= 1'b0;
            rsp_thread_id <= 3'(cur_ff);
            rsp_instr_line <= '0;
            rsp_mem_read <= 1'b0; rsp_mem_write <= 1'b0;
            rsp_mem_address <= '0; rsp_store_data <= '0;
            rsp_cycle_count <= cyc_ff; rsp_instr_count <= ins_ff;
            rsp_all_halted <= every_halted;
         end
      end
   end

   `include "multithread_issue_core_unit_assert.svh"
   `MIC_ASSERT_NEXT(a_rsp_beat, reset, cmd.adv2 || cmd.exe_wb || cmd.ldr || cmd.skip, rsp_valid, "missing beat")
   `MIC_ASSERT_IMPL(a_rw_excl, reset, rsp_valid, !(rsp_mem_read && rsp_mem_write), "read and write")
   `MIC_ASSERT_NEXT(a_cyc_mono, reset, !cmd.clear, cyc_ff >= $past(cyc_ff), "cycle count fell")
endmodule

>>> rtl/core/multithread_issue_core_unit.sv
// Multithreaded issue core. One beat on start (taken when busy is low)
// gives exactly one result beat, flagged by rsp_valid for a single cycle;
// the receiver cannot stall, so capture it then. An advance beat runs a
// tick-and-pick step, then a penalty-and-fetch step; an execute beat runs
// a register read, then an update; a store reads its base register in a
// step of its own between them, as the file has two read ports; busy
// is high from the accepting edge until the last step, whose edge puts out
// the result beat. A load return, or a beat of the unused mode 3, is taken
// in the idle state and busy stays low. After reset a clearing pass zeroes
// the register file, one word per cycle, with busy high; CSR writes are
// taken at any time but belong between beats.
module multithread_issue_core_unit
   import mic_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_mode,
   input  logic [2:0]        req_opcode,
   input  logic [2:0]        req_dest_reg,
   input  logic [2:0]        req_src1_reg,
   input  logic signed [31:0] req_src2_or_imm,
   input  logic              req_src2_is_imm,
   input  logic signed [31:0] req_load_data,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [7:0]        csr_data,
   output logic              rsp_valid,
   output logic              rsp_idle,
   output logic              rsp_all_halted,
   output logic [2:0]        rsp_thread_id,
   output logic [15:0]       rsp_instr_line,
   output logic              rsp_mem_read,
   output logic              rsp_mem_write,
   output logic signed [31:0] rsp_mem_address,
   output logic signed [31:0] rsp_store_data,
   output logic [47:0]       rsp_cycle_count,
   output logic [47:0]       rsp_instr_count
);
   logic       mt_mode_ff;
   logic [3:0] active_ff;
   logic [7:0] load_lat_ff, store_lat_ff, sw_pen_ff;
   dp_cmd_type cmd;
   dp_sts_type sts;

   // CSR bank
   always_ff @(posedge clock) begin
      if (reset) begin
         mt_mode_ff <= 1'b0; active_ff <= 4'd8;
         load_lat_ff <= '0; store_lat_ff <= '0; sw_pen_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MT_MODE:   mt_mode_ff   <= csr_data[0];
            CSR_ACTIVE:    active_ff    <= csr_data[3:0];
            CSR_LOAD_LAT:  load_lat_ff  <= csr_data;
            CSR_STORE_LAT: store_lat_ff <= csr_data;
            CSR_SW_PEN:    sw_pen_ff    <= csr_data;
            default:       mt_mode_ff   <= mt_mode_ff;
         endcase
      end
   end

   mic_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .mode(req_mode),
      .busy(busy), .cmd(cmd), .sts(sts)
   );

   mic_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .cfg_mt_mode(mt_mode_ff), .cfg_active(active_ff),
      .cfg_load_lat(load_lat_ff), .cfg_store_lat(store_lat_ff),
      .cfg_sw_pen(sw_pen_ff),
      .opcode(req_opcode), .dest_reg(req_dest_reg), .src1_reg(req_src1_reg),
      .src2_or_imm(req_src2_or_imm), .src2_is_imm(req_src2_is_imm),
      .load_data(req_load_data),
      .rsp_valid(rsp_valid), .rsp_idle(rsp_idle),
      .rsp_all_halted(rsp_all_halted), .rsp_thread_id(rsp_thread_id),
      .rsp_instr_line(rsp_instr_line), .rsp_mem_read(rsp_mem_read),
      .rsp_mem_write(rsp_mem_write), .rsp_mem_address(rsp_mem_address),
      .rsp_store_data(rsp_store_data), .rsp_cycle_count(rsp_cycle_count),
      .rsp_instr_count(rsp_instr_count)
   );
endmodule
